// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/bsil_pkg.sv -----
// Shared types, codes and helpers of the bounded sorted insertion list
`default_nettype none

package bsil_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int APB_DATA_W   = 32;
    localparam int PADDR_W      = 3;

    // Opcodes of an input word
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Register index, taken from paddr[2]
    localparam logic REG_DESC_ORDER = 1'b0;

    typedef struct packed {
        logic               op;
        logic [15:0]        item_id;
        logic signed [31:0] sort_key;
    } item_t;

    typedef struct packed {
        logic [15:0]        out_id;
        logic signed [31:0] out_key;
        logic               last;
        logic               empty_res;
    } res_t;

    typedef struct packed {
        logic [15:0]        id;
        logic signed [31:0] key;
    } entry_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic rd_issue;
        logic ins_step;
        logic ins_tail;
        logic emit;
        logic emit_empty;
        logic clear;
    } ctl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic idx_end;
        logic pend;
        logic full;
        logic empty;
    } dp_status_t;

    // True when the stored key lies strictly beyond the new key
    function automatic logic beyond(input logic signed [31:0] stored,
                                    input logic signed [31:0] fresh,
                                    input logic desc);
        logic res;
        res = desc ? (fresh > stored) : (stored > fresh);
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- design/bounded_sorted_insert_list_core.sv -----
// Insert: busy from the accepting edge until the walk has written the list's tail entry.
// Flush: the first result word passes the RAM read register and the result register, then
//   one word per cycle, busy until the walk ends; an empty list gives one word in the next cycle, never busy.
// Full-list inserts drop in the accepting cycle; other inserts and flushes of a non-empty
//   list walk the list once through its single read port, and the block stays busy meanwhile.
// Reset clears the entry count, the order register and the controller; results cannot stall.
`default_nettype none

module bounded_sorted_insert_list_core #(
    parameter int CAPACITY = bsil_pkg::CAPACITY_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire bsil_pkg::item_t                   cmd,
    output logic                                   res_valid,
    output bsil_pkg::res_t                         res,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bsil_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [bsil_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [bsil_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    logic                 desc_order_reg;
    logic                 desc_order_next;
    logic                 reg_sel;
    bsil_pkg::ctl_cmd_t   ctl_cmd;
    bsil_pkg::dp_status_t dp_status;

    // Register write decode
    assign reg_sel = (paddr[2] == bsil_pkg::REG_DESC_ORDER);

    always_comb
    begin
        desc_order_next = desc_order_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            desc_order_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_order_reg <= 1'b0;
        end
        else
        begin
            desc_order_reg <= desc_order_next;
        end
    end

    assign prdata = reg_sel ? {{(bsil_pkg::APB_DATA_W-1){1'b0}}, desc_order_reg} : '0;
    assign pready = 1'b1;

    bsil_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (cmd.op),
        .status (dp_status),
        .cmd    (ctl_cmd),
        .busy   (busy)
    );

    bsil_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (cmd),
        .desc_order (desc_order_reg),
        .cmd        (ctl_cmd),
        .status     (dp_status),
        .res_valid  (res_valid),
        .res        (res)
    );

endmodule

`default_nettype wire

// ----- design/bsil_ram.sv -----
// Generic simple dual-port RAM with registered read
`default_nettype none

module bsil_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/bsil_ctrl.sv -----
// Controller state machine: sequences insert walks and flush walks
`default_nettype none

module bsil_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                op,
    input  wire bsil_pkg::dp_status_t status,
    output bsil_pkg::ctl_cmd_t       cmd,
    output logic                     busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_INS   = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Decode state and status into datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op == bsil_pkg::OP_INSERT)
                    begin
                        // Drop inserts into a full list
                        if (!status.full)
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_INS;
                        end
                    end
                    else if (status.empty)
                    begin
                        cmd.emit_empty = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_FLUSH;
                    end
                end
            end
            S_INS:
            begin
                cmd.rd_issue = !status.idx_end;
                cmd.ins_step = status.pend;
                if (status.idx_end && !status.pend)
                begin
                    cmd.ins_tail = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                cmd.rd_issue = !status.idx_end;
                cmd.emit     = status.pend;
                if (status.idx_end && !status.pend)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- design/bsil_dp.sv -----
// Datapath: entry memory, walk index, insert carry and result register
`default_nettype none

module bsil_dp #(
    parameter int CAPACITY = bsil_pkg::CAPACITY_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bsil_pkg::item_t      item,
    input  wire logic                 desc_order,
    input  wire bsil_pkg::ctl_cmd_t   cmd,
    output bsil_pkg::dp_status_t      status,
    output logic                      res_valid,
    output bsil_pkg::res_t            res
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     prev_idx;
    logic                 pend_reg;
    logic                 ins_reg, ins_next;
    bsil_pkg::entry_t     new_reg, new_next;
    bsil_pkg::entry_t     carry_reg, carry_next;
    bsil_pkg::res_t       res_reg, res_next;
    logic                 res_valid_reg;
    bsil_pkg::entry_t     rd_entry;
    bsil_pkg::entry_t     wr_entry;
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic                 hit;

    bsil_ram #(
        .WIDTH ($bits(bsil_pkg::entry_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_entry),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rd_entry)
    );

    // Entry now in rdata was read at the previous index
    assign prev_idx = idx_reg - CNT_W'(1);
    assign hit      = !ins_reg && bsil_pkg::beyond(rd_entry.key, new_reg.key, desc_order);

    // Walk the list: on insert place the new word, then ripple each entry one slot up; on flush emit each entry
    always_comb
    begin
        idx_next   = idx_reg;
        count_next = count_reg;
        ins_next   = ins_reg;
        new_next   = new_reg;
        carry_next = carry_reg;
        res_next   = res_reg;
        we         = 1'b0;
        waddr      = prev_idx[ADDR_W-1:0];
        wr_entry   = new_reg;

        if (cmd.load)
        begin
            idx_next     = '0;
            ins_next     = 1'b0;
            new_next.id  = item.item_id;
            new_next.key = item.sort_key;
        end
        if (cmd.rd_issue)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (cmd.ins_step)
        begin
            if (hit)
            begin
                we         = 1'b1;
                wr_entry   = new_reg;
                ins_next   = 1'b1;
                carry_next = rd_entry;
            end
            else if (ins_reg)
            begin
                we         = 1'b1;
                wr_entry   = carry_reg;
                carry_next = rd_entry;
            end
        end
        if (cmd.ins_tail)
        begin
            we         = 1'b1;
            waddr      = count_reg[ADDR_W-1:0];
            wr_entry   = ins_reg ? carry_reg : new_reg;
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.emit)
        begin
            res_next.out_id    = rd_entry.id;
            res_next.out_key   = rd_entry.key;
            res_next.last      = status.idx_end;
            res_next.empty_res = 1'b0;
        end
        if (cmd.emit_empty)
        begin
            res_next           = '0;
            res_next.empty_res = 1'b1;
        end
        if (cmd.clear || cmd.emit_empty)
        begin
            count_next = '0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            ins_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pend_reg      <= cmd.rd_issue;
            ins_reg       <= ins_next;
            res_valid_reg <= cmd.emit || cmd.emit_empty;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        new_reg   <= new_next;
        carry_reg <= carry_next;
        res_reg   <= res_next;
    end

    assign status.idx_end = (idx_reg == count_reg);
    assign status.pend    = pend_reg;
    assign status.full    = (count_reg == CNT_W'(CAPACITY));
    assign status.empty   = (count_reg == '0);
    assign res_valid      = res_valid_reg;
    assign res            = res_reg;

endmodule

`default_nettype wire

// ----- design/bsil_checker.sv -----
// Port-level checker for the sorted insertion list, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module bsil_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           res_valid,
    input wire bsil_pkg::res_t res,
    input wire logic           pready
);

    `ASSERT_CLK(a_pready_high, clk, rst_n, pready, "pready dropped")
    `ASSERT_NEVER(a_empty_clean, clk, rst_n, res_valid && res.empty_res && (res.last || res.out_id != 16'd0 || res.out_key != 32'sd0), "empty word carries data")
    `ASSERT_CLK(a_entry_while_busy, clk, rst_n, (res_valid && !res.empty_res) |-> busy, "entry word outside a flush")
    `ASSERT_CLK(a_last_ends, clk, rst_n, (res_valid && res.last && !res.empty_res) |=> !res_valid, "word after last")
    `ASSERT_CLK(a_busy_from_start, clk, rst_n, $rose(busy) |-> $past(start), "busy without a start")

endmodule

bind bounded_sorted_insert_list_core bsil_checker u_bsil_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .pready    (pready)
);

`default_nettype wire

// ----- bench/tb_bounded_sorted_insert_list_core.sv -----
// Testbench for the bounded sorted insertion list: directed and random command words checked against a list model
module tb_bounded_sorted_insert_list_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP = bsil_pkg::CAPACITY_DEF;
    localparam int HELD_MAX = (LIST_CAP > 64) ? 64 : LIST_CAP;
    localparam logic [bsil_pkg::PADDR_W-1:0] ORDER_ADDR = {bsil_pkg::REG_DESC_ORDER, 2'b00};
    localparam int SETTLE_CYCLES = HELD_MAX + 8;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    bsil_pkg::item_t                 cmd = '0;
    logic                            res_valid;
    bsil_pkg::res_t                  res;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [bsil_pkg::PADDR_W-1:0]    paddr = '0;
    logic [bsil_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [bsil_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // Model of the held list
    logic [15:0]        held_ids [64];
    logic signed [31:0] held_keys [64];
    int                 held_count = 0;
    logic               desc_mode = 1'b0;

    bsil_pkg::item_t cmd_queue [$];
    bsil_pkg::res_t  due_words [$];
    int              mismatches = 0;
    bit              steady = 1'b0;
    int              planned_count = 0;
    int              counted = 0;

    bounded_sorted_insert_list_core #(
        .CAPACITY (LIST_CAP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    // Insert into the model list or queue up the words a flush will emit
    task automatic apply_to_list(input bsil_pkg::item_t it);
        int                 pos;
        logic signed [31:0] fresh;
        bsil_pkg::res_t     w;
        fresh = it.sort_key;
        if (it.op == bsil_pkg::OP_INSERT)
        begin
            if (held_count >= HELD_MAX)
                return;
            pos = held_count;
            for (int k = 0; k < held_count; k++)
            begin
                if (desc_mode ? (fresh > held_keys[k]) : (held_keys[k] > fresh))
                begin
                    pos = k;
                    break;
                end
            end
            for (int k = held_count; k > pos; k--)
            begin
                held_ids[k]  = held_ids[k-1];
                held_keys[k] = held_keys[k-1];
            end
            held_ids[pos]  = it.item_id;
            held_keys[pos] = fresh;
            held_count++;
        end
        else if (held_count == 0)
        begin
            w = '0;
            w.empty_res = 1'b1;
            due_words.push_back(w);
        end
        else
        begin
            for (int k = 0; k < held_count; k++)
            begin
                w.out_id    = held_ids[k];
                w.out_key   = held_keys[k];
                w.last      = (k + 1 == held_count);
                w.empty_res = 1'b0;
                due_words.push_back(w);
            end
            held_count = 0;
        end
    endtask

    // Retire the accepted word and present the next one, with random gaps unless steady
    always @(posedge clk)
    begin : drive_p
        bsil_pkg::item_t taken;
        bit              go;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                taken = cmd_queue.pop_front();
                apply_to_list(taken);
            end
            go = (cmd_queue.size() != 0) && (steady || $urandom_range(99) >= 33);
            start <= go;
            if (go)
                cmd <= cmd_queue[0];
        end
    end

    // Check each result word against the oldest expected one
    always @(posedge clk)
    begin : check_p
        bsil_pkg::res_t want;
        if (rst_n && res_valid)
        begin
            if (due_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: id %h key %0d last %b empty %b",
                             res.out_id, res.out_key, res.last, res.empty_res);
            end
            else
            begin
                want = due_words.pop_front();
                if (res.out_id !== want.out_id || res.out_key !== want.out_key ||
                    res.last !== want.last || res.empty_res !== want.empty_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("word mismatch: got id %h key %0d last %b empty %b",
                                 res.out_id, res.out_key, res.last, res.empty_res);
                        $display("               want id %h key %0d last %b empty %b",
                                 want.out_id, want.out_key, want.last, want.empty_res);
                    end
                end
            end
        end
    end

    task automatic queue_insert(input logic [15:0] id, input logic signed [31:0] key);
        bsil_pkg::item_t it;
        it.op       = bsil_pkg::OP_INSERT;
        it.item_id  = id;
        it.sort_key = key;
        cmd_queue.push_back(it);
        counted++;
        // Track how many entries the list will hold; inserts into a full list are dropped
        if (planned_count < HELD_MAX)
            planned_count++;
    endtask

    task automatic queue_flush(input logic [15:0] id, input logic signed [31:0] key);
        bsil_pkg::item_t it;
        it.op       = bsil_pkg::OP_FLUSH;
        it.item_id  = id;
        it.sort_key = key;
        cmd_queue.push_back(it);
        planned_count = 0;
        counted++;
    endtask

    function automatic logic signed [31:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return $urandom;
        else if (sel < 75)
            return $signed($urandom_range(6)) - 3;
        else if (sel < 85)
            return 32'sh7FFFFFFF;
        else if (sel < 95)
            return 32'sh80000000;
        else
            return $urandom_range(1) ? 32'sd1 : -32'sd1;
    endfunction

    // Hold until every word is taken and the block has gone quiet
    task automatic settle();
        while (cmd_queue.size() != 0 || start || busy || due_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_order(input logic v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ORDER_ADDR;
        pwdata  <= {{(bsil_pkg::APB_DATA_W-1){1'b0}}, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        desc_mode = v;
    endtask

    initial
    begin
        int len;
        int sel;
        int phase_end;
        bit long_done;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_order(1'b0);

        // Directed: empty flush, extremes and ties in ascending order
        queue_flush(16'hFFFF, -32'sd1);
        queue_insert(16'hFFFF, 32'sh7FFFFFFF);
        queue_insert(16'h0000, 32'sh80000000);
        queue_insert(16'h0001, 32'sd0);
        queue_insert(16'h0002, 32'sd0);
        queue_insert(16'h0003, -32'sd1);
        queue_insert(16'h5A5A, 32'sd1);
        queue_insert(16'h0004, 32'sd0);
        queue_flush(16'h0000, 32'sd0);
        queue_insert(16'h0007, 32'sd5);
        queue_flush(16'hA5A5, 32'sh5A5A5A5A);
        settle();

        // Directed: descending order with ties and extremes
        write_order(1'b1);
        queue_insert(16'h0010, 32'sd0);
        queue_insert(16'h0011, 32'sh7FFFFFFF);
        queue_insert(16'h0012, 32'sh80000000);
        queue_insert(16'h0013, 32'sd0);
        queue_insert(16'h0014, -32'sd5);
        queue_flush(16'h0000, 32'sd0);

        // Directed: flip direction while entries are held
        queue_insert(16'h0020, 32'sd100);
        queue_insert(16'h0021, 32'sd50);
        settle();
        write_order(1'b0);
        queue_insert(16'h0022, 32'sd75);
        queue_insert(16'h0023, 32'sd200);
        queue_flush(16'hFFFF, 32'sh7FFFFFFF);

        // Random phases, each under its own direction; one phase runs without gaps
        long_done = 1'b0;
        for (int ph = 0; counted < 160; ph++)
        begin
            settle();
            write_order(ph % 2 == 0);
            steady = (ph == 1);
            phase_end = counted + 32;
            while (counted < phase_end)
            begin
                sel = $urandom_range(99);
                if ((ph == 2 && !long_done) || sel < 4)
                begin
                    len = $urandom_range(70, 64);
                    long_done = 1'b1;
                end
                else if (sel < 14)
                    len = 0;
                else
                    len = $urandom_range(10, 1);
                for (int i = 0; i < len; i++)
                    queue_insert(16'($urandom_range(65535)), pick_key());
                // Now and then keep the list across the next sequence or phase
                if ($urandom_range(9) != 0)
                    queue_flush(16'($urandom_range(65535)), $urandom);
            end
        end
        if (planned_count > 0)
            queue_flush(16'($urandom_range(65535)), $urandom);

        settle();
        if (mismatches == 0 && due_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/bsil_pkg.sv
design/bsil_ram.sv
design/bsil_ctrl.sv
design/bsil_dp.sv
design/bounded_sorted_insert_list_core.sv
design/bsil_checker.sv
bench/tb_bounded_sorted_insert_list_core.sv
